@@ hw/rtl/mhfl_pkg.sv @@
// Package with the types, constants and helpers of the mail header field locator.
`default_nettype none

package mhfl_pkg;

  localparam int MaxNameChars = 16;
  localparam int OffsetBits   = 24;
  localparam int NameLenBits  = $clog2(MaxNameChars + 1);
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = 64;

  localparam logic [CfgIndexBits-1:0] RegNameLow  = 2'd0;
  localparam logic [CfgIndexBits-1:0] RegNameHigh = 2'd1;
  localparam logic [CfgIndexBits-1:0] RegNameLen  = 2'd2;

  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic [OffsetBits-1:0] OffsetMax = {OffsetBits{1'b1}};

  typedef enum logic [3:0] {
    MODE_NAME      = 4'd0,
    MODE_COLON     = 4'd1,
    MODE_SKIP      = 4'd2,
    MODE_AFTER_LF  = 4'd3,
    MODE_AFTER_CR  = 4'd4,
    MODE_VALUE     = 4'd5,
    MODE_FOLD_CR   = 4'd6,
    MODE_FOLD_LF   = 4'd7,
    MODE_FOLD_CRLF = 4'd8
  } scan_mode_t;

  typedef struct packed {
    logic                  found;
    logic [OffsetBits-1:0] value_offset;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mail_header_field_locator.sv @@
// Top level of the mail header field locator: scanner, result register and skid stage.
//
// Article bytes enter on the s_ side, one byte per word, with s_tlast on the final
// byte. The block compares the first line that starts with the configured header
// name (case blind, then a colon and a blank), skips blanks and folded lines, and
// gives exactly one result word per article on the m_ side: m_tuser is the found
// flag and m_tdata the offset of the first value byte, or zero when not found.
// Bytes after the result are ignored until s_tlast, which also restarts the scan.
// The name is set through cfg_we, cfg_index and cfg_data while the block is idle.
// One byte is accepted every cycle while s_tready is high; the work for a byte is one
// pass of the scan state machine between the scan registers and the result register.
// The result that a byte causes is registered before it shows on m_tvalid.
// When the receiver stalls, one further result is held in a skid register, so
// s_tready drops only while that skid register is full.
// Reset clears the scan state, the valid flags of both result registers and the name registers
// (name length one, all name characters zero).
`default_nettype none

module mail_header_field_locator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,   // data_byte [7:0]
  input  wire logic                                s_tlast,   // last_byte
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [mhfl_pkg::OffsetBits-1:0]          m_tdata,   // value_offset [23:0]
  output logic                                     m_tuser,   // found
  input  wire logic                                cfg_we,
  input  wire logic [mhfl_pkg::CfgIndexBits-1:0]   cfg_index,
  input  wire logic [mhfl_pkg::CfgDataBits-1:0]    cfg_data
);
  import mhfl_pkg::*;

  typedef struct packed {
    scan_mode_t             mode;
    logic [NameLenBits-1:0] pos;
  } cmp_t;

  logic [63:0]            name_chars_low;
  logic [63:0]            name_chars_high;
  logic [NameLenBits-1:0] name_length;

  scan_mode_t             scan_mode, scan_mode_next;
  logic [NameLenBits-1:0] name_position, name_position_next;
  logic [OffsetBits-1:0]  byte_position, byte_position_next;
  logic                   result_given, result_given_next;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_reg;
  result_t skid;
  logic    out_valid;
  logic    skid_valid;

  logic [NameLenBits-1:0] eff_len;
  logic [7:0]             c;
  cmp_t                   cmp_cont;
  cmp_t                   cmp_begin;

  assign eff_len = (name_length > NameLenBits'(MaxNameChars)) ?
                   NameLenBits'(MaxNameChars) : name_length;
  assign c = s_tdata;

  function automatic logic [7:0] name_char(input logic [NameLenBits-1:0] k,
                                           input logic [63:0] lo,
                                           input logic [63:0] hi);
    logic [127:0] all;
    all = {hi, lo};
    return all[{k[3:0], 3'b000} +: 8];
  endfunction

  function automatic cmp_t compare_byte(input scan_mode_t m,
                                        input logic [NameLenBits-1:0] p,
                                        input logic [7:0] ch,
                                        input logic [NameLenBits-1:0] len,
                                        input logic [63:0] lo,
                                        input logic [63:0] hi);
    cmp_t r;
    r.mode = m;
    r.pos  = p;
    if (ch == ChLf) begin
      r.mode = MODE_AFTER_LF;
    end else if (m == MODE_COLON) begin
      r.mode = is_blank(ch) ? MODE_VALUE : MODE_SKIP;
    end else if (p < len) begin
      if (fold_case(ch) == fold_case(name_char(p, lo, hi))) begin
        r.pos = p + 1'b1;
      end else begin
        r.mode = MODE_SKIP;
      end
    end else begin
      r.mode = (ch == ChColon) ? MODE_COLON : MODE_SKIP;
    end
    return r;
  endfunction

  assign cmp_cont  = compare_byte(scan_mode, name_position, c, eff_len,
                                  name_chars_low, name_chars_high);
  assign cmp_begin = compare_byte(MODE_NAME, '0, c, eff_len,
                                  name_chars_low, name_chars_high);

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    logic done;
    logic found;
    done               = 1'b0;
    found              = 1'b0;
    scan_mode_next     = scan_mode;
    name_position_next = name_position;
    byte_position_next = byte_position;
    result_given_next  = result_given;
    res_valid          = 1'b0;
    res.found          = 1'b0;
    res.value_offset   = '0;
    if (accept) begin
      if (!result_given) begin
        case (scan_mode)
          MODE_NAME, MODE_COLON: begin
            scan_mode_next     = cmp_cont.mode;
            name_position_next = cmp_cont.pos;
          end
          MODE_SKIP: begin
            if (c == ChLf) begin
              scan_mode_next = MODE_AFTER_LF;
            end
          end
          MODE_AFTER_LF: begin
            if (c == ChLf) begin
              done = 1'b1;
            end else if (c == ChCr) begin
              scan_mode_next = MODE_AFTER_CR;
            end else begin
              scan_mode_next     = cmp_begin.mode;
              name_position_next = cmp_begin.pos;
            end
          end
          MODE_AFTER_CR: begin
            if (c == ChLf) begin
              done = 1'b1;
            end else begin
              scan_mode_next     = cmp_begin.mode;
              name_position_next = cmp_begin.pos;
            end
          end
          MODE_VALUE: begin
            if (c == ChCr) begin
              scan_mode_next = MODE_FOLD_CR;
            end else if (c == ChLf) begin
              scan_mode_next = MODE_FOLD_LF;
            end else if (!is_blank(c)) begin
              found = 1'b1;
              done  = 1'b1;
            end
          end
          MODE_FOLD_CR: begin
            if (is_blank(c)) begin
              scan_mode_next = MODE_VALUE;
            end else if (c == ChLf) begin
              scan_mode_next = MODE_FOLD_CRLF;
            end else begin
              done = 1'b1;
            end
          end
          default: begin
            if (is_blank(c)) begin
              scan_mode_next = MODE_VALUE;
            end else begin
              done = 1'b1;
            end
          end
        endcase
        if (s_tlast) begin
          done = 1'b1;
        end
        if (done) begin
          result_given_next = 1'b1;
          res_valid         = 1'b1;
          res.found         = found;
          res.value_offset  = found ? byte_position : '0;
        end
      end
      if (s_tlast) begin
        scan_mode_next     = MODE_NAME;
        name_position_next = '0;
        byte_position_next = '0;
        result_given_next  = 1'b0;
      end else if (byte_position != OffsetMax) begin
        byte_position_next = byte_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_NAME;
      name_position <= '0;
      byte_position <= '0;
      result_given  <= 1'b0;
    end else begin
      scan_mode     <= scan_mode_next;
      name_position <= name_position_next;
      byte_position <= byte_position_next;
      result_given  <= result_given_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_chars_low  <= '0;
      name_chars_high <= '0;
      name_length     <= NameLenBits'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        RegNameLow:  name_chars_low  <= cfg_data;
        RegNameHigh: name_chars_high <= cfg_data;
        RegNameLen:  name_length     <= cfg_data[NameLenBits-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_reg <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg.value_offset;
  assign m_tuser  = out_reg.found;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> !result_given && byte_position == '0)
    else $error("scan state not restarted after last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast && !result_given |=> m_tvalid)
    else $error("no result for an article ending without one");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    result_given && accept && !s_tlast |-> !res_valid)
    else $error("second result for one article");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not-found result with nonzero offset");

endmodule

`default_nettype wire

@@ tb/sv/mhfl_checker.sv @@
// Checker that mirrors the locator's name registers and scan and compares every result word.
module mhfl_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [7:0]                        s_tdata,
  input  logic                              s_tlast,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [mhfl_pkg::OffsetBits-1:0]   m_tdata,
  input  logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [mhfl_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [mhfl_pkg::CfgDataBits-1:0]  cfg_data,
  output int                                fail_count,
  output int                                results_waiting,
  output int                                results_seen,
  output int                                located_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import mhfl_pkg::*;

  logic [63:0] name_lo;
  logic [63:0] name_hi;
  logic [4:0] name_len;

  scan_mode_t mode;
  logic [4:0] matched;
  logic [OffsetBits-1:0] byte_pos;
  logic reported;

  result_t expected_q[$];
  int fails = 0;
  int waiting = 0;
  int seen = 0;
  int located = 0;

  assign fail_count = fails;
  assign results_waiting = waiting;
  assign results_seen = seen;
  assign located_seen = located;

  task automatic report_mismatch(input string what);
    if (fails < 100) begin
      $display("%0t: result %0d mismatch: %s", $realtime, seen, what);
    end
    fails++;
  endtask

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab;
  endfunction

  function automatic logic [7:0] name_byte(input logic [4:0] k);
    return k[3] ? name_hi[8*k[2:0] +: 8] : name_lo[8*k[2:0] +: 8];
  endfunction

  task automatic clear_scan();
    mode = MODE_NAME;
    matched = '0;
    byte_pos = '0;
    reported = 1'b0;
  endtask

  // One byte of the line prefix: the name, then the colon, then one blank.
  task automatic match_prefix(input logic [7:0] c);
    logic [4:0] len;
    len = (name_len > 5'(MaxNameChars)) ? 5'(MaxNameChars) : name_len;
    if (c == ChLf) begin
      mode = MODE_AFTER_LF;
    end else if (mode == MODE_COLON) begin
      mode = blank(c) ? MODE_VALUE : MODE_SKIP;
    end else if (matched < len) begin
      if (lower(c) == lower(name_byte(matched))) begin
        matched++;
      end else begin
        mode = MODE_SKIP;
      end
    end else begin
      mode = (c == ChColon) ? MODE_COLON : MODE_SKIP;
    end
  endtask

  task automatic start_line(input logic [7:0] c);
    mode = MODE_NAME;
    matched = '0;
    match_prefix(c);
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic last);
    logic done;
    logic hit;
    result_t r;
    done = 1'b0;
    hit = 1'b0;
    if (!reported) begin
      case (mode)
        MODE_NAME, MODE_COLON: match_prefix(c);
        MODE_SKIP: begin
          if (c == ChLf) mode = MODE_AFTER_LF;
        end
        MODE_AFTER_LF: begin
          if (c == ChLf) done = 1'b1;
          else if (c == ChCr) mode = MODE_AFTER_CR;
          else start_line(c);
        end
        MODE_AFTER_CR: begin
          if (c == ChLf) done = 1'b1;
          else start_line(c);
        end
        MODE_VALUE: begin
          if (c == ChCr) begin
            mode = MODE_FOLD_CR;
          end else if (c == ChLf) begin
            mode = MODE_FOLD_LF;
          end else if (!blank(c)) begin
            hit = 1'b1;
            done = 1'b1;
          end
        end
        MODE_FOLD_CR: begin
          if (blank(c)) mode = MODE_VALUE;
          else if (c == ChLf) mode = MODE_FOLD_CRLF;
          else done = 1'b1;
        end
        default: begin
          if (blank(c)) mode = MODE_VALUE;
          else done = 1'b1;
        end
      endcase
      if (last) done = 1'b1;
      if (done) begin
        reported = 1'b1;
        r.found = hit;
        r.value_offset = hit ? byte_pos : '0;
        expected_q.push_back(r);
      end
    end
    if (last) begin
      clear_scan();
    end else if (byte_pos != OffsetMax) begin
      byte_pos++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      name_lo = '0;
      name_hi = '0;
      name_len = 5'd1;
      clear_scan();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegNameLow: name_lo = cfg_data[63:0];
          RegNameHigh: name_hi = cfg_data[63:0];
          RegNameLen: name_len = cfg_data[4:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("found %0b offset %0d arrived with none expected",
                                    m_tuser, m_tdata));
        end else begin
          want = expected_q.pop_front();
          if (m_tuser !== want.found) begin
            report_mismatch($sformatf("found %b, expected %b", m_tuser, want.found));
          end
          if (m_tdata !== want.value_offset) begin
            report_mismatch($sformatf("offset %0d, expected %0d", m_tdata, want.value_offset));
          end
        end
        seen++;
        if (m_tuser === 1'b1) located++;
      end
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
    end
    waiting = expected_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the mail header field locator: clock, reset, article stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mhfl_pkg::*;

  localparam int PhaseBytes = 155;
  localparam int HoldCycles = 200;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OffsetBits-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index = RegNameLow;
  logic [CfgDataBits-1:0] cfg_data = '0;

  int fail_count;
  int results_waiting;
  int results_seen;
  int located_seen;

  logic want_hold = 1'b0;
  logic held_once = 1'b0;
  logic hold_active = 1'b0;
  logic no_gaps = 1'b0;

  logic [7:0] name_c[MaxNameChars] = '{default: 8'h00};
  int name_n = 1;
  logic [7:0] specials[5] = '{ChLf, ChCr, ChColon, ChSpace, ChTab};
  logic [7:0] art_q[$];
  int bytes_sent = 0;
  int articles_sent = 0;

  mail_header_field_locator dut (.*);

  mhfl_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_len(input logic quiet);
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 65) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  function automatic logic [7:0] noise_byte();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return specials[$urandom_range(0, 4)];
    if (p < 65) return flip_case(name_c[$urandom_range(0, MaxNameChars - 1)]);
    return 8'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_len(no_gaps || hold_active);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_article();
    for (int i = 0; i < art_q.size(); i++) begin
      send_byte(art_q[i], i == art_q.size() - 1);
    end
    articles_sent++;
  endtask

  task automatic put_line_end();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) begin
      art_q.push_back(ChCr);
    end else begin
      if (p < 40) art_q.push_back(ChCr);
      art_q.push_back(ChLf);
    end
  endtask

  task automatic put_text(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) art_q.push_back(8'($urandom));
      else art_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
    end
  endtask

  task automatic put_filler_line();
    repeat ($urandom_range(1, 5)) art_q.push_back(flip_case(8'($urandom_range(8'h61, 8'h7a))));
    art_q.push_back(ChColon);
    art_q.push_back(ChSpace);
    put_text($urandom_range(0, 5));
    put_line_end();
  endtask

  // A line that carries the configured name, now and then broken in one place.
  task automatic put_target_line(input logic first);
    int n;
    int bad;
    int p;
    n = (name_n > MaxNameChars) ? MaxNameChars : name_n;
    bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : -1;
    if (!first && $urandom_range(0, 5) == 0) art_q.push_back(ChCr);
    for (int k = 0; k < n; k++) begin
      art_q.push_back(k == bad ? 8'($urandom) : flip_case(name_c[k]));
    end
    art_q.push_back(bad == n ? 8'($urandom) : ChColon);
    p = $urandom_range(0, 99);
    if (p < 85) art_q.push_back(rand_blank());
    else if (p < 93) art_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
    repeat ($urandom_range(0, 2)) art_q.push_back(rand_blank());
    if ($urandom_range(0, 3) == 0) begin
      put_line_end();
      if ($urandom_range(0, 5) != 0) begin
        repeat ($urandom_range(1, 2)) art_q.push_back(rand_blank());
      end
    end
    if ($urandom_range(0, 99) < 80) put_text($urandom_range(1, 6));
    put_line_end();
  endtask

  task automatic build_article(input logic tiny);
    int lines;
    int target_at;
    int n;
    art_q.delete();
    if (tiny || $urandom_range(0, 99) < 15) begin
      repeat (tiny ? $urandom_range(1, 3) : $urandom_range(1, 12)) art_q.push_back(noise_byte());
    end else begin
      lines = $urandom_range(1, 3);
      target_at = $urandom_range(0, lines);
      for (int l = 0; l < lines; l++) begin
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1)) art_q.push_back(ChCr);
          art_q.push_back(ChLf);
        end
        if (l == target_at) put_target_line(l == 0);
        else put_filler_line();
      end
      if ($urandom_range(0, 3) == 0) begin
        art_q.push_back(ChLf);
        put_text($urandom_range(1, 6));
      end
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, art_q.size());
        while (art_q.size() > n) void'(art_q.pop_back());
      end
    end
  endtask

  task automatic load_name();
    logic [63:0] lo;
    logic [63:0] hi;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = name_c[k];
      hi[8*k +: 8] = name_c[k + 8];
    end
    cfg_we <= 1'b1;
    cfg_index <= RegNameLow;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= RegNameHigh;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= RegNameLen;
    cfg_data <= CfgDataBits'(name_n);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_name(input int ph);
    for (int k = 0; k < MaxNameChars; k++) begin
      case (ph)
        6: name_c[k] = (k < 8) ? 8'hff : 8'h00;
        7: name_c[k] = 8'($urandom);
        8: name_c[k] = (k < 8) ? 8'h00 : 8'hff;
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            name_c[k] = $urandom_range(0, 1) ? 8'($urandom_range(8'h30, 8'h39)) : 8'h2d;
          end else begin
            name_c[k] = flip_case(8'($urandom_range(8'h61, 8'h7a)));
          end
        end
      endcase
    end
    case (ph)
      1: name_n = 1;
      2: name_n = $urandom_range(3, 8);
      3, 6: name_n = 16;
      4: name_n = 0;
      5: name_n = 20;
      7: name_n = $urandom_range(1, 16);
      default: name_n = 31;
    endcase
    load_name();
  endtask

  task automatic wait_idle();
    int guard;
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    guard = 0;
    while (results_waiting != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    int stall;
    forever begin
      if (want_hold && !held_once) begin
        held_once = 1'b1;
        hold_active = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        stall = idle_len(1'b0);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int phase_start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset name is one NUL character.
    art_q = '{8'h00, ChColon, ChSpace, 8'hff};
    send_article();
    art_q = '{ChLf, ChLf, 8'h41};
    send_article();
    art_q = '{ChLf, ChCr, 8'h00, ChColon, ChTab, 8'h7a};
    send_article();
    art_q = '{8'h00, ChColon, ChSpace, ChLf, 8'h41};
    send_article();
    art_q = '{8'h00, ChColon, ChSpace, ChLf, ChCr};
    send_article();
    art_q = '{8'h41, 8'h42};
    send_article();

    for (int ph = 1; ph <= 8; ph++) begin
      wait_idle();
      pick_name(ph);
      if (ph == 2) begin
        want_hold = 1'b1;
        while (!hold_active) @(posedge clk);
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes || hold_active) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        build_article(hold_active);
        send_article();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (results_waiting != 0) begin
      $display("%0d expected results never arrived", results_waiting);
    end
    $display("Streamed %0d bytes in %0d articles under 9 header name settings,",
             bytes_sent, articles_sent);
    $display("including a long receiver stall; %0d results checked, %0d with a located value.",
             results_seen, located_seen);
    if (fail_count == 0 && results_waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("timeout: the locator stopped making progress");
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mhfl_pkg.sv
hw/rtl/mail_header_field_locator.sv
tb/sv/mhfl_checker.sv
tb/sv/tb_top.sv
